// ----- hdl/etsync_pkg.sv -----
package etsync_pkg;

    // counter and register widths
    localparam int CNT_W  = 7;
    localparam int REG_W  = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [REG_W-1:0] reg_val_t;

    localparam cnt_t CNT_MAX = cnt_t'(127);

    // register reset values
    localparam reg_val_t MAX_WAIT_RST  = reg_val_t'(30);
    localparam reg_val_t REQ_MATCH_RST = reg_val_t'(10);
    localparam reg_val_t MAX_RETRY_RST = reg_val_t'(10);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WAIT   = 2'd0,
        CFG_REQ_MATCH  = 2'd1,
        CFG_MAX_RETRY  = 2'd2
    } cfg_idx_t;

    // sync modes
    typedef enum logic [2:0] {
        MODE_RESETTING     = 3'd0,
        MODE_INITIALIZING  = 3'd1,
        MODE_VALIDATING    = 3'd2,
        MODE_SYNC_CHECKING = 3'd3,
        MODE_SYNCHRONIZED  = 3'd4,
        MODE_FAILED        = 3'd5
    } mode_t;

    // toggle-mode commands
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_OFF  = 2'd1,
        CMD_ON   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic reference_on;
        logic current_on;
    } in_item_t;

    typedef struct packed {
        logic       synced;
        logic [1:0] command;
        logic [2:0] mode;
    } out_item_t;

    typedef struct packed {
        reg_val_t max_wait_frames;
        reg_val_t required_matches;
        reg_val_t max_retries;
    } cfg_t;

    // saturating increment
    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

endpackage

// ----- hdl/emitter_toggle_sync_fsm.sv -----
// channel   ports                            dir  payload
// s_        s_valid, s_ready, s_data         in   reference_on, current_on
// m_        m_valid, m_ready, m_data         out  synced, command, mode
// cfg_      cfg_we, cfg_index, cfg_wdata     in   max_wait_frames, required_matches,
//                                                 max_retries
//
// one frame per cycle sustained while m_ready stays high; a frame is taken into the
// input register at its s_ transfer, and the state update then moves its result into
// the result register that drives m_data
// aresetn is synchronous, active low: resetting mode, counters cleared,
// registers back to 30 / 10 / 10
// m_ready low holds the result register; the input register still takes one
// more frame, then s_ready drops until the result is taken
module emitter_toggle_sync_fsm
    import etsync_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata
);

    cfg_t      cfg;
    out_item_t step_result;

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;
    logic      out_load;
    logic      step_en;

    // result register free or emptying this cycle
    assign out_load = !m_valid_reg || m_ready;
    assign step_en  = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || step_en;

    etsync_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    etsync_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_data_reg <= step_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hdl/etsync_cfg.sv -----
module etsync_cfg
    import etsync_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode, unknown indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_WAIT:  cfg_next.max_wait_frames  = cfg_wdata;
                CFG_REQ_MATCH: cfg_next.required_matches = cfg_wdata;
                CFG_MAX_RETRY: cfg_next.max_retries      = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_wait_frames  <= MAX_WAIT_RST;
            cfg_reg.required_matches <= REQ_MATCH_RST;
            cfg_reg.max_retries      <= MAX_RETRY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/etsync_fsm.sv -----
module etsync_fsm
    import etsync_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    mode_t mode_reg, mode_next;
    cnt_t  wait_count_reg, wait_count_next;
    cnt_t  match_count_reg, match_count_next;
    cnt_t  retry_count_reg, retry_count_next;
    logic  previous_on_reg, previous_on_next;

    cnt_t  wait_inc, match_inc, retry_inc;
    logic  wait_ok, retry_ok, match_done;
    logic  ref_eq_cur, cur_changed, both_on;
    logic  first_frame;

    // shared counter arithmetic
    assign wait_inc    = sat_inc(wait_count_reg);
    assign match_inc   = sat_inc(match_count_reg);
    assign retry_inc   = sat_inc(retry_count_reg);
    assign wait_ok     = wait_count_reg <= {1'b0, cfg.max_wait_frames};
    assign retry_ok    = retry_inc <= {1'b0, cfg.max_retries};
    assign match_done  = match_inc >= {1'b0, cfg.required_matches};
    assign ref_eq_cur  = item.reference_on == item.current_on;
    assign cur_changed = item.current_on != previous_on_reg;
    assign both_on     = item.current_on && previous_on_reg;
    assign first_frame = wait_count_reg == '0;

    // next state and counters
    always_comb begin
        logic do_wait;
        logic do_retry;
        mode_next        = mode_reg;
        wait_count_next  = wait_count_reg;
        match_count_next = match_count_reg;
        retry_count_next = retry_count_reg;
        previous_on_next = item.current_on;
        do_wait          = 1'b0;
        do_retry         = 1'b0;

        unique case (mode_reg)
            MODE_RESETTING: begin
                if (first_frame) begin
                    wait_count_next = cnt_t'(1);
                end else if (both_on && match_done) begin
                    mode_next        = MODE_INITIALIZING;
                    match_count_next = '0;
                    wait_count_next  = '0;
                end else begin
                    if (both_on) begin
                        match_count_next = match_inc;
                    end
                    do_wait = 1'b1;
                end
            end
            MODE_INITIALIZING: begin
                if (first_frame) begin
                    wait_count_next = cnt_t'(1);
                end else if (cur_changed) begin
                    mode_next        = MODE_VALIDATING;
                    match_count_next = '0;
                    wait_count_next  = '0;
                end else begin
                    do_wait = 1'b1;
                end
            end
            MODE_VALIDATING: begin
                if (cur_changed && match_done) begin
                    mode_next        = MODE_SYNC_CHECKING;
                    match_count_next = '0;
                    wait_count_next  = '0;
                end else begin
                    if (cur_changed) begin
                        match_count_next = match_inc;
                    end
                    do_wait = 1'b1;
                end
            end
            MODE_SYNC_CHECKING: begin
                if (ref_eq_cur) begin
                    match_count_next = match_inc;
                    if (match_done) begin
                        mode_next = MODE_SYNCHRONIZED;
                    end
                end else begin
                    do_retry = 1'b1;
                end
            end
            MODE_SYNCHRONIZED: begin
                if (!ref_eq_cur) begin
                    do_retry = 1'b1;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase

        // wait timeout turns into a retry
        if (do_wait) begin
            if (wait_ok) begin
                wait_count_next = wait_inc;
            end else begin
                do_retry = 1'b1;
            end
        end

        // retry or give up
        if (do_retry) begin
            retry_count_next = retry_inc;
            if (retry_ok) begin
                mode_next        = MODE_RESETTING;
                wait_count_next  = '0;
                match_count_next = '0;
            end else begin
                mode_next = MODE_FAILED;
            end
        end
    end

    // per-frame outputs
    always_comb begin
        result.synced  = 1'b0;
        result.command = CMD_NONE;
        result.mode    = mode_next;
        unique case (mode_reg)
            MODE_RESETTING: begin
                if (first_frame) begin
                    result.command = CMD_OFF;
                end
            end
            MODE_INITIALIZING: begin
                if (first_frame) begin
                    result.command = CMD_ON;
                end
            end
            MODE_SYNC_CHECKING: begin
                result.synced = ref_eq_cur && match_done;
            end
            MODE_SYNCHRONIZED: begin
                result.synced = ref_eq_cur;
            end
            default: begin
                result.synced = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_RESETTING;
            wait_count_reg  <= '0;
            match_count_reg <= '0;
            retry_count_reg <= '0;
            previous_on_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg        <= mode_next;
            wait_count_reg  <= wait_count_next;
            match_count_reg <= match_count_next;
            retry_count_reg <= retry_count_next;
            previous_on_reg <= previous_on_next;
        end
    end

    // a command goes out only on the first frame of a mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.command != CMD_NONE |-> wait_count_reg == '0)
        else $error("command issued outside first frame");

    // failed is terminal until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_FAILED |=> mode_reg == MODE_FAILED)
        else $error("left failed mode");

    // synced only reported in synchronized mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.synced |-> result.mode == MODE_SYNCHRONIZED)
        else $error("synced outside synchronized mode");

    // state holds between frames
    assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !step_en |=> $stable(mode_reg) && $stable(retry_count_reg))
        else $error("state moved without a frame");

endmodule

// ----- tb/sv/tb_emitter_toggle_sync_fsm.sv -----
`timescale 1ns / 1ps

module tb_emitter_toggle_sync_fsm;
    import etsync_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_LINES = 40;

    // tracked copy of the sync state plus the status of the last frame
    typedef struct packed {
        mode_t     mode;
        cnt_t      wait_cnt;
        cnt_t      match_cnt;
        cnt_t      retry_cnt;
        logic      prev_on;
        reg_val_t  max_wait;
        reg_val_t  req_matches;
        reg_val_t  max_retry;
        out_item_t status;
    } sync_model_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_wdata = '0;

    in_item_t    frame_q[$];
    out_item_t   status_q[$];
    sync_model_t tracked;
    sync_model_t planned;
    int          frames_queued = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;

    emitter_toggle_sync_fsm u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------
    // sync state machine prediction
    // ---------------------------------------------------------------

    function automatic cnt_t bump(input cnt_t v);
        return (&v) ? v : cnt_t'(v + 1);
    endfunction

    function automatic sync_model_t reset_model();
        sync_model_t st;
        st = '0;
        st.mode        = MODE_RESETTING;
        st.max_wait    = MAX_WAIT_RST;
        st.req_matches = REQ_MATCH_RST;
        st.max_retry   = MAX_RETRY_RST;
        return st;
    endfunction

    function automatic sync_model_t enter_mode(input sync_model_t st, input mode_t m);
        st.mode      = m;
        st.wait_cnt  = '0;
        st.match_cnt = '0;
        return st;
    endfunction

    // wait and match counters are kept as they are when the retries run out
    function automatic sync_model_t take_retry(input sync_model_t st);
        st.retry_cnt = bump(st.retry_cnt);
        if (st.retry_cnt <= st.max_retry) begin
            st = enter_mode(st, MODE_RESETTING);
        end else begin
            st.mode = MODE_FAILED;
        end
        return st;
    endfunction

    // the wait counter may pass the limit by one before the timeout
    function automatic sync_model_t wait_or_retry(input sync_model_t st);
        if (st.wait_cnt <= st.max_wait) begin
            st.wait_cnt = bump(st.wait_cnt);
        end else begin
            st = take_retry(st);
        end
        return st;
    endfunction

    function automatic sync_model_t sync_step(input sync_model_t st, input in_item_t f);
        sync_model_t n;
        logic        hit;
        n = st;
        n.status = '0;
        n.status.command = CMD_NONE;
        case (st.mode)
            MODE_RESETTING: begin
                // first frame only issues the command
                if (st.wait_cnt == 0) begin
                    n.status.command = CMD_OFF;
                    n.wait_cnt = cnt_t'(1);
                end else begin
                    hit = f.current_on && st.prev_on;
                    if (hit) n.match_cnt = bump(st.match_cnt);
                    if (hit && n.match_cnt >= st.req_matches) begin
                        n = enter_mode(n, MODE_INITIALIZING);
                    end else begin
                        n = wait_or_retry(n);
                    end
                end
            end
            MODE_INITIALIZING: begin
                if (st.wait_cnt == 0) begin
                    n.status.command = CMD_ON;
                    n.wait_cnt = cnt_t'(1);
                end else if (f.current_on != st.prev_on) begin
                    n = enter_mode(n, MODE_VALIDATING);
                end else begin
                    n = wait_or_retry(n);
                end
            end
            MODE_VALIDATING: begin
                hit = f.current_on != st.prev_on;
                if (hit) n.match_cnt = bump(st.match_cnt);
                if (hit && n.match_cnt >= st.req_matches) begin
                    n = enter_mode(n, MODE_SYNC_CHECKING);
                end else begin
                    n = wait_or_retry(n);
                end
            end
            MODE_SYNC_CHECKING: begin
                if (f.reference_on == f.current_on) begin
                    n.match_cnt = bump(st.match_cnt);
                    if (n.match_cnt >= st.req_matches) begin
                        n.mode = MODE_SYNCHRONIZED;
                        n.status.synced = 1'b1;
                    end
                end else begin
                    n = take_retry(n);
                end
            end
            MODE_SYNCHRONIZED: begin
                if (f.reference_on == f.current_on) begin
                    n.status.synced = 1'b1;
                end else begin
                    n = take_retry(n);
                end
            end
            default: begin
            end
        endcase
        n.prev_on = f.current_on;
        n.status.mode = n.mode;
        return n;
    endfunction

    // ---------------------------------------------------------------
    // stimulus planning
    // ---------------------------------------------------------------

    // a frame that moves the machine toward synchronized
    function automatic in_item_t clean_frame(input sync_model_t st);
        in_item_t f;
        f = in_item_t'($urandom_range(0, 3));
        case (st.mode)
            MODE_RESETTING: begin
                if (st.wait_cnt != 0) f.current_on = 1'b1;
            end
            MODE_INITIALIZING: begin
                if (st.wait_cnt != 0) f.current_on = ~st.prev_on;
            end
            MODE_VALIDATING: begin
                f.current_on = ~st.prev_on;
            end
            MODE_SYNC_CHECKING, MODE_SYNCHRONIZED: begin
                f.reference_on = f.current_on;
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    task automatic push_frame(input in_item_t f);
        planned = sync_step(planned, f);
        frame_q.push_back(f);
        frames_queued++;
    endtask

    // clean frames with random content, mixed with noise; retries are rationed
    // so that the terminal failed mode is only reached when allowed
    task automatic queue_frames(input int count, input int noise_pct, input int retry_budget,
                                input bit allow_fail);
        in_item_t    f;
        sync_model_t trial;
        int          retries;
        retries = 0;
        for (int i = 0; i < count; i++) begin
            f = clean_frame(planned);
            if ($urandom_range(0, 99) < noise_pct) f = in_item_t'($urandom_range(0, 3));
            trial = sync_step(planned, f);
            if (trial.retry_cnt != planned.retry_cnt &&
                (retries >= retry_budget || (trial.mode == MODE_FAILED && !allow_fail))) begin
                f = clean_frame(planned);
                trial = sync_step(planned, f);
            end
            // settings that time out even on clean frames: stop before failing
            if (trial.mode == MODE_FAILED && planned.mode != MODE_FAILED && !allow_fail) break;
            if (trial.retry_cnt != planned.retry_cnt) retries++;
            push_frame(f);
        end
    endtask

    task automatic wait_drained();
        while (results_seen != frames_queued) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input int wait_lim, input int match_req, input int retries);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_WAIT;
        cfg_wdata <= reg_val_t'(wait_lim);
        @(posedge aclk);
        cfg_index <= CFG_REQ_MATCH;
        cfg_wdata <= reg_val_t'(match_req);
        @(posedge aclk);
        cfg_index <= CFG_MAX_RETRY;
        cfg_wdata <= reg_val_t'(retries);
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracked.max_wait    = reg_val_t'(wait_lim);
        tracked.req_matches = reg_val_t'(match_req);
        tracked.max_retry   = reg_val_t'(retries);
        planned.max_wait    = reg_val_t'(wait_lim);
        planned.req_matches = reg_val_t'(match_req);
        planned.max_retry   = reg_val_t'(retries);
    endtask

    task automatic run_phase(input int wait_lim, input int match_req, input int retries,
                             input int send_pct, input int recv_pct, input bit long_hold,
                             input int count, input int noise_pct, input int retry_budget,
                             input bit allow_fail);
        wait_drained();
        write_regs(wait_lim, match_req, retries);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_off       = long_hold;
        queue_frames(count, noise_pct, retry_budget, allow_fail);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        // keep the log short when the block is badly broken
        if (mismatches <= MAX_LINES)
            $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // frame driver
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (frame_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= frame_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver, with one long hold-off when asked
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : receiver
        int hold_left;
        bit hold_done;
        if (!aresetn) begin
            hold_left = 0;
            hold_done = 1'b0;
            m_ready <= 1'b0;
        end else if (hold_off && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor: check result transfers, then predict from frame transfers
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (status_q.size() == 0) begin
                    report_mismatch("result with no frame pending", m_data, 0);
                end else begin
                    want = status_q.pop_front();
                    if (m_data.synced !== want.synced)
                        report_mismatch("synced", m_data.synced, want.synced);
                    if (m_data.command !== want.command)
                        report_mismatch("command", m_data.command, want.command);
                    if (m_data.mode !== want.mode)
                        report_mismatch("mode", m_data.mode, want.mode);
                end
            end
            if (s_valid && s_ready) begin
                tracked = sync_step(tracked, s_data);
                status_q.push_back(tracked.status);
            end
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        // walk through every mode but failed and every timeout, {reference_on, current_on}
        logic [1:0] walk [26] = '{
            2'b01, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01, 2'b11, 2'b01, 2'b10,
            2'b01, 2'b10, 2'b11, 2'b00, 2'b10, 2'b01, 2'b11, 2'b10, 2'b01,
            2'b01, 2'b11, 2'b11, 2'b01, 2'b00, 2'b11, 2'b00, 2'b10
        };
        int wait_lim;
        int match_req;

        tracked = reset_model();
        planned = reset_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // register values straight out of reset
        queue_frames(60, 10, 2, 1'b0);

        // directed walk with the wait limit at zero and one match needed
        wait_drained();
        write_regs(0, 1, 63);
        foreach (walk[i]) push_frame(in_item_t'(walk[i]));

        // upper extremes, no idling
        run_phase(63, 63, 63, 0, 0, 1'b0, 200, 3, 3, 1'b0);
        // sender idling
        run_phase(8, 5, 63, 65, 0, 1'b0, 200, 15, 8, 1'b0);
        // zero match count, receiver stalling
        run_phase(20, 0, 63, 0, 65, 1'b0, 200, 10, 6, 1'b0);
        // short limits, both sides idling, heavy noise
        run_phase(3, 4, 63, 30, 30, 1'b0, 250, 25, 10, 1'b0);
        // receiver holds off for a long stretch while frames keep coming
        run_phase(12, 6, 63, 0, 0, 1'b1, 150, 5, 3, 1'b0);
        // match count out of reach of the wait limit: resetting times out
        run_phase(5, 20, 63, 30, 30, 1'b0, 60, 10, 6, 1'b0);

        // random mid-range settings
        wait_lim  = $urandom_range(4, 40);
        match_req = $urandom_range(1, wait_lim + 1);
        run_phase(wait_lim, match_req, 63, $urandom_range(0, 1) ? 30 : 0,
                  $urandom_range(0, 1) ? 30 : 0, 1'b0, 150, 10, 4, 1'b0);

        // no retries left: the next retry ends in the failed mode
        run_phase(10, 3, 0, 30, 30, 1'b0, 80, 30, 80, 1'b1);

        while (results_seen != frames_queued) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (status_q.size() != 0)
            report_mismatch("frames still awaiting a result", status_q.size(), 0);
        if (mismatches == 0) begin
            $display("[emitter_toggle_sync_fsm] OK");
        end else begin
            $display("[emitter_toggle_sync_fsm] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #(CLK_PERIOD * 400000);
        $display("[emitter_toggle_sync_fsm] ERROR");
        $finish;
    end

endmodule
